// ===== rtl/core/bld_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery low detector package
// Shared widths, reset values and register indexes of the battery low
// detector.
// ----------------------------------------------------------------------------
package bld_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int ADC_BITS_DEF = 12;
	localparam int CAL_W        = 12;
	localparam int MV_W         = 16;
	localparam int LVL_W        = 10;
	localparam int THR_W        = 7;
	localparam int MAR_W        = 6;
	localparam int CFG_W        = 16;
	localparam int IDX_W        = 3;
	localparam int PROD_W       = 24;
	localparam int DIFF_W       = PROD_W + 1;
	localparam int SCL_W        = 31;
	localparam int CMP_W        = LVL_W + 1;

	localparam int FULL_SCALE_MV = 3300;
	localparam int PERCENT       = 100;

	localparam logic [CAL_W-1:0] CAL_RST  = CAL_W'(1520);
	localparam logic [MV_W-1:0]  VMIN_RST = MV_W'(2700);
	localparam logic [MV_W-1:0]  SPAN_RST = MV_W'(600);
	localparam logic [THR_W-1:0] THR_RST  = THR_W'(15);
	localparam logic [MAR_W-1:0] MAR_RST  = MAR_W'(2);

	localparam logic [IDX_W-1:0] REG_CAL  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_VMIN = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_SPAN = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_THR  = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_MAR  = IDX_W'(4);

	localparam logic signed [LVL_W-1:0] LVL_MAX = LVL_W'(511);
	localparam logic signed [LVL_W-1:0] LVL_MIN = LVL_W'(-512);

	typedef logic signed [LVL_W-1:0] level_t;

endpackage

// ===== rtl/core/battery_low_detector_hysteresis.sv =====
// ----------------------------------------------------------------------------
// Battery low detector with hysteresis
// Converts a reference-channel ADC sample to supply millivolts and a charge
// level in percent, and keeps a low-battery flag with a hysteresis band.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A nonzero sample runs through
// the millivolt divider, the difference and scale steps, the level divider
// (skipped when the span is zero) and the hysteresis step before its result
// is ready. A zero sample skips both dividers and goes straight to the done
// state with a divide error result. Only one sample is in work at a time; a
// new sample is accepted while a finished result still waits on the output.
module battery_low_detector_hysteresis #(
	parameter int ADC_BITS = bld_pkg::ADC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bld_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         low_battery,
	output logic signed [bld_pkg::LVL_W-1:0] charge_level,
	output logic [bld_pkg::MV_W-1:0]     supply_mv,
	output logic                         divide_error,
	input  logic                         cfg_we,
	input  logic [bld_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bld_pkg::CFG_W-1:0]    cfg_wdata
);
	import bld_pkg::*;

	localparam int SMP_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV1  = 3'd1;
	localparam logic [2:0] ST_DIFF  = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_DIV2  = 3'd4;
	localparam logic [2:0] ST_HYST  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]       state_q;
	logic [CAL_W-1:0] cal_q;
	logic [MV_W-1:0]  vmin_q;
	logic [MV_W-1:0]  span_q;
	logic [THR_W-1:0] thr_q;
	logic [MAR_W-1:0] mar_q;
	logic             was_low_q;

	logic [PROD_W-1:0]      volts_q;
	logic signed [DIFF_W-1:0] diff_q;
	level_t                 level_q;
	logic                   res_low_q;
	level_t                 res_lvl_q;
	logic [MV_W-1:0]        res_mv_q;
	logic                   res_err_q;

	logic             out_valid_q;
	logic             out_low_q;
	level_t           out_lvl_q;
	logic [MV_W-1:0]  out_mv_q;
	logic             out_err_q;

	logic              in_accept;
	logic [SMP_W-1:0]  sample;
	logic              sample_zero;
	logic [PROD_W-1:0] product;
	logic              div1_start;
	logic              div1_done;
	logic [PROD_W-1:0] div1_quo;

	logic [DIFF_W-1:0] diff_mag;
	logic [SCL_W-1:0]  scaled;
	logic              div2_start;
	logic              div2_done;
	logic [SCL_W-1:0]  div2_quo;
	level_t            level_clamp;
	level_t            level_zero_span;

	logic signed [CMP_W-1:0] lvl_ext;
	logic signed [CMP_W-1:0] thr_hi;
	logic signed [CMP_W-1:0] thr_lo;
	logic                    low_next;
	logic                    out_free;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign sample      = adc_sample[SMP_W-1:0];
	assign sample_zero = (sample == '0);
	assign product     = PROD_W'(FULL_SCALE_MV) * PROD_W'(cal_q);
	assign div1_start  = in_accept && !sample_zero;

	bld_sdiv #(
		.NUM_W(PROD_W),
		.DEN_W(SMP_W)
	) u_div_mv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div1_start),
		.num    (product),
		.den    (sample),
		.done   (div1_done),
		.quo    (div1_quo)
	);

	assign diff_mag   = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign scaled     = SCL_W'(diff_mag) * SCL_W'(PERCENT);
	assign div2_start = (state_q == ST_SCALE) && (span_q != '0);

	bld_sdiv #(
		.NUM_W(SCL_W),
		.DEN_W(MV_W)
	) u_div_lvl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div2_start),
		.num    (scaled),
		.den    (span_q),
		.done   (div2_done),
		.quo    (div2_quo)
	);

	always_comb begin
		if (diff_q[DIFF_W-1]) begin
			if (div2_quo > SCL_W'(512)) begin
				level_clamp = LVL_MIN;
			end else begin
				level_clamp = level_t'(-div2_quo[LVL_W-1:0]);
			end
		end else begin
			if (div2_quo > SCL_W'(511)) begin
				level_clamp = LVL_MAX;
			end else begin
				level_clamp = level_t'(div2_quo[LVL_W-1:0]);
			end
		end
	end

	always_comb begin
		if (diff_q[DIFF_W-1]) begin
			level_zero_span = LVL_MIN;
		end else if (diff_q != '0) begin
			level_zero_span = LVL_MAX;
		end else begin
			level_zero_span = '0;
		end
	end

	// The saturated level gives the same decisions, since both bounds lie
	// well inside the output range.
	assign lvl_ext  = CMP_W'(level_q);
	assign thr_hi   = $signed(CMP_W'(thr_q) + CMP_W'(mar_q));
	assign thr_lo   = $signed(CMP_W'(thr_q) - CMP_W'(mar_q));
	assign low_next = was_low_q ? (lvl_ext < thr_hi) : (lvl_ext <= thr_lo);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q  <= CAL_RST;
			vmin_q <= VMIN_RST;
			span_q <= SPAN_RST;
			thr_q  <= THR_RST;
			mar_q  <= MAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL:  cal_q  <= cfg_wdata[CAL_W-1:0];
				REG_VMIN: vmin_q <= cfg_wdata[MV_W-1:0];
				REG_SPAN: span_q <= cfg_wdata[MV_W-1:0];
				REG_THR:  thr_q  <= cfg_wdata[THR_W-1:0];
				REG_MAR:  mar_q  <= cfg_wdata[MAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			was_low_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= sample_zero ? ST_DONE : ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div1_done) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= (span_q != '0) ? ST_DIV2 : ST_HYST;
				end
				ST_DIV2: begin
					if (div2_done) begin
						state_q <= ST_HYST;
					end
				end
				ST_HYST: begin
					was_low_q <= low_next;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && sample_zero) begin
			res_low_q <= was_low_q;
			res_lvl_q <= '0;
			res_mv_q  <= '0;
			res_err_q <= 1'b1;
		end
		if ((state_q == ST_DIV1) && div1_done) begin
			volts_q <= div1_quo;
		end
		if (state_q == ST_DIFF) begin
			diff_q <= $signed(DIFF_W'(volts_q)) - $signed(DIFF_W'(vmin_q));
		end
		if ((state_q == ST_SCALE) && (span_q == '0)) begin
			level_q <= level_zero_span;
		end
		if ((state_q == ST_DIV2) && div2_done) begin
			level_q <= level_clamp;
		end
		if (state_q == ST_HYST) begin
			res_low_q <= low_next;
			res_lvl_q <= level_q;
			res_mv_q  <= (volts_q[PROD_W-1:MV_W] != '0) ? '1 : volts_q[MV_W-1:0];
			res_err_q <= 1'b0;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_low_q <= res_low_q;
			out_lvl_q <= res_lvl_q;
			out_mv_q  <= res_mv_q;
			out_err_q <= res_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign low_battery  = out_low_q;
	assign charge_level = out_lvl_q;
	assign supply_mv    = out_mv_q;
	assign divide_error = out_err_q;

endmodule

// ===== rtl/core/bld_sdiv.sv =====
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division that retires one quotient bit per cycle. The dividend
// shifts out of the top of a shift register while the quotient bits shift in.
// ----------------------------------------------------------------------------
module bld_sdiv #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule
